### rtl/core/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types and constants of the direct-mapped cache tag check block.
// ----------------------------------------------------------------------------
package dmc_pkg;

  localparam int TAG_W       = 32;
  localparam int LINE_IDX_W  = 8;
  localparam int CNT_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TAG_BITS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IS_LOAD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BACK  = 3'd4;

  typedef struct packed {
    logic                  hit;
    logic                  cold_miss;
    logic [LINE_IDX_W-1:0] line_index;
    logic [TAG_W-1:0]      line_tag;
    logic                  line_dirty;
    logic [CNT_W-1:0]      hit_total;
    logic [CNT_W-1:0]      miss_total;
  } res_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EVAL
  } bk_state_t;

endpackage

### rtl/core/direct_mapped_cache_tag_check.sv
// An accepted item waits in the request queue, is popped in BK_IDLE and is evaluated
// in BK_EVAL, which pushes its result into the result queue that feeds the out_ ports.
// One item is evaluated at a time: the tag RAM is read, then updated, before the next pop.
// After reset a clearing pass writes every line, during which in_full stays high.
// Configuration registers reset to tag 8, index 2, offset 2, load, write-through.
// ----------------------------------------------------------------------------
// direct_mapped_cache_tag_check
// Tag store of a direct-mapped cache: classifies each address as hit, cold
// miss or conflict miss, installs tags, tracks dirty bits and counts hits.
// ----------------------------------------------------------------------------
module direct_mapped_cache_tag_check
  import dmc_pkg::*;
#(
  parameter int MAX_INDEX_BITS = 8,
  parameter int ADDR_WIDTH     = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [ADDR_WIDTH-1:0] in_address,
  input  logic                  out_pop,
  output logic                  out_empty,
  output logic                  out_hit,
  output logic                  out_cold_miss,
  output logic [LINE_IDX_W-1:0] out_line_index,
  output logic [TAG_W-1:0]      out_line_tag,
  output logic                  out_line_dirty,
  output logic [CNT_W-1:0]      out_hit_total,
  output logic [CNT_W-1:0]      out_miss_total
);

  localparam int REQ_W = MAX_INDEX_BITS + TAG_W + 1;
  localparam int RES_W = $bits(res_t);

  logic [REQ_W-1:0] req_wdata;
  logic [REQ_W-1:0] req_rdata;
  logic             req_full;
  logic             req_empty;
  logic             req_pop;
  logic             clearing;
  logic             res_push;
  logic             res_full;
  res_t             res_wdata;
  logic [RES_W-1:0] res_rdata;
  res_t             res_out;

  assign in_full = req_full || clearing;

  dmc_front #(
    .MAX_INDEX_BITS (MAX_INDEX_BITS),
    .ADDR_WIDTH     (ADDR_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_address (in_address),
    .req_wdata  (req_wdata)
  );

  dmc_fifo #(
    .WIDTH (REQ_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_req_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && !in_full),
    .wdata (req_wdata),
    .full  (req_full),
    .pop   (req_pop),
    .rdata (req_rdata),
    .empty (req_empty)
  );

  dmc_back #(
    .MAX_INDEX_BITS (MAX_INDEX_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_empty (req_empty),
    .req_rdata (req_rdata),
    .req_pop   (req_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_wdata (res_wdata),
    .clearing  (clearing)
  );

  dmc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign res_out        = res_t'(res_rdata);
  assign out_hit        = res_out.hit;
  assign out_cold_miss  = res_out.cold_miss;
  assign out_line_index = res_out.line_index;
  assign out_line_tag   = res_out.line_tag;
  assign out_line_dirty = res_out.line_dirty;
  assign out_hit_total  = res_out.hit_total;
  assign out_miss_total = res_out.miss_total;

endmodule

### rtl/core/dmc_ram.sv
// ----------------------------------------------------------------------------
// dmc_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module dmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/dmc_fifo.sv
// ----------------------------------------------------------------------------
// dmc_fifo
// Small synchronous queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module dmc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### rtl/core/dmc_front.sv
// ----------------------------------------------------------------------------
// dmc_front
// Configuration registers and address split into line index and tag.
// ----------------------------------------------------------------------------
module dmc_front
  import dmc_pkg::*;
#(
  parameter int MAX_INDEX_BITS = 8,
  parameter int ADDR_WIDTH     = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_wdata,
  input  logic [ADDR_WIDTH-1:0]             in_address,
  output logic [MAX_INDEX_BITS+TAG_W:0]     req_wdata
);

  localparam int XW = ADDR_WIDTH + TAG_W;

  logic [5:0] tag_bits_r;
  logic [3:0] index_bits_r;
  logic [4:0] offset_bits_r;
  logic       is_load_r;
  logic       write_back_r;

  logic [5:0]                tb;
  logic [4:0]                ib;
  logic [6:0]                total;
  logic [5:0]                tag_shamt;
  logic [ADDR_WIDTH-1:0]     addr_mask;
  logic [MAX_INDEX_BITS-1:0] idx_mask;
  logic [TAG_W-1:0]          tag_mask;
  logic [XW-1:0]             addr_ext;
  logic [XW-1:0]             idx_sh;
  logic [XW-1:0]             tag_sh;
  logic [MAX_INDEX_BITS-1:0] idx;
  logic [TAG_W-1:0]          tag;
  logic                      dirty_on_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_bits_r    <= 6'd8;
      index_bits_r  <= 4'd2;
      offset_bits_r <= 5'd2;
      is_load_r     <= 1'b1;
      write_back_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TAG_BITS:    tag_bits_r    <= cfg_wdata[5:0];
        CFG_INDEX_BITS:  index_bits_r  <= cfg_wdata[3:0];
        CFG_OFFSET_BITS: offset_bits_r <= cfg_wdata[4:0];
        CFG_IS_LOAD:     is_load_r     <= cfg_wdata[0];
        CFG_WRITE_BACK:  write_back_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tb = (tag_bits_r > 6'(TAG_W)) ? 6'(TAG_W) : tag_bits_r;
    ib = ({1'b0, index_bits_r} > 5'(MAX_INDEX_BITS)) ?
         5'(MAX_INDEX_BITS) : {1'b0, index_bits_r};
    total     = 7'(tb) + 7'(ib) + 7'(offset_bits_r);
    tag_shamt = 6'(offset_bits_r) + 6'(ib);
    for (int i = 0; i < ADDR_WIDTH; i++) begin
      addr_mask[i] = (32'(i) < 32'(total));
    end
    for (int i = 0; i < MAX_INDEX_BITS; i++) begin
      idx_mask[i] = (32'(i) < 32'(ib));
    end
    for (int i = 0; i < TAG_W; i++) begin
      tag_mask[i] = (32'(i) < 32'(tb));
    end
    addr_ext     = XW'(in_address & addr_mask);
    idx_sh       = addr_ext >> offset_bits_r;
    tag_sh       = addr_ext >> tag_shamt;
    idx          = idx_sh[MAX_INDEX_BITS-1:0] & idx_mask;
    tag          = tag_sh[TAG_W-1:0] & tag_mask;
    dirty_on_hit = !is_load_r && write_back_r;
    req_wdata    = {dirty_on_hit, tag, idx};
  end

endmodule

### rtl/core/dmc_back.sv
// ----------------------------------------------------------------------------
// dmc_back
// Tag RAM lookup and update, hit and miss counters, and the clearing pass.
// ----------------------------------------------------------------------------
module dmc_back
  import dmc_pkg::*;
#(
  parameter int MAX_INDEX_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_empty,
  input  logic [MAX_INDEX_BITS+TAG_W:0] req_rdata,
  output logic                          req_pop,
  input  logic                          res_full,
  output logic                          res_push,
  output res_t                          res_wdata,
  output logic                          clearing
);

  localparam int REQ_W  = MAX_INDEX_BITS + TAG_W + 1;
  localparam int RAM_W  = TAG_W + 2;
  localparam int NLINES = 2 ** MAX_INDEX_BITS;

  bk_state_t state_r, state_nxt;

  logic [MAX_INDEX_BITS-1:0] clr_addr_r, clr_addr_nxt;
  logic [REQ_W-1:0]          hold_r, hold_nxt;
  logic [CNT_W-1:0]          hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0]          miss_cnt_r, miss_cnt_nxt;

  logic                      ram_we;
  logic [MAX_INDEX_BITS-1:0] ram_waddr;
  logic [RAM_W-1:0]          ram_wdata;
  logic [RAM_W-1:0]          ram_rdata;

  logic [MAX_INDEX_BITS-1:0] hold_idx;
  logic [TAG_W-1:0]          hold_tag;
  logic                      hold_doh;
  logic                      rd_valid;
  logic                      rd_dirty;
  logic [TAG_W-1:0]          rd_tag;
  logic                      hit;
  logic                      new_dirty;

  assign hold_idx  = hold_r[MAX_INDEX_BITS-1:0];
  assign hold_tag  = hold_r[MAX_INDEX_BITS +: TAG_W];
  assign hold_doh  = hold_r[REQ_W-1];
  assign rd_valid  = ram_rdata[RAM_W-1];
  assign rd_dirty  = ram_rdata[RAM_W-2];
  assign rd_tag    = ram_rdata[TAG_W-1:0];
  assign hit       = rd_valid && (rd_tag == hold_tag);
  assign new_dirty = hit && (rd_dirty || hold_doh);
  assign clearing  = (state_r == BK_CLEAR);

  dmc_ram #(
    .WIDTH (RAM_W),
    .DEPTH (NLINES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (req_rdata[MAX_INDEX_BITS-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: begin
        if (&clr_addr_r) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!req_empty && !res_full) begin
          state_nxt = BK_EVAL;
        end
      end
      BK_EVAL: state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = hold_idx;
    ram_wdata    = {1'b1, new_dirty, hold_tag};
    req_pop      = 1'b0;
    res_push     = 1'b0;
    clr_addr_nxt = clr_addr_r;
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    case (state_r)
      BK_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      BK_IDLE: begin
        req_pop = !req_empty && !res_full;
      end
      BK_EVAL: begin
        ram_we   = 1'b1;
        res_push = 1'b1;
        if (hit) begin
          if (hit_cnt_r != '1) begin
            hit_cnt_nxt = hit_cnt_r + 1'b1;
          end
        end else begin
          if (miss_cnt_r != '1) begin
            miss_cnt_nxt = miss_cnt_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
    hold_nxt = req_pop ? req_rdata : hold_r;

    res_wdata.hit        = hit;
    res_wdata.cold_miss  = !rd_valid;
    res_wdata.line_index = LINE_IDX_W'(hold_idx);
    res_wdata.line_tag   = hold_tag;
    res_wdata.line_dirty = new_dirty;
    res_wdata.hit_total  = hit_cnt_nxt;
    res_wdata.miss_total = miss_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_CLEAR;
      clr_addr_r <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_CLEAR) |-> !req_pop)
    else $error("Item taken from the queue during the clearing pass.");

  a_pop_leads_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    req_pop |=> (state_r == BK_EVAL))
    else $error("Popped item was not evaluated in the next cycle.");

  a_result_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("Result pushed into a full queue.");

  a_one_count_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_EVAL) |=> (hit_cnt_r == $past(hit_cnt_r)) &&
                             (miss_cnt_r == $past(miss_cnt_r)))
    else $error("Counter moved outside of an evaluation cycle.");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the direct-mapped cache tag check block. Address
// items are sent in bursts from a pending queue, and every accepted item is
// run through a local model of the tag store that predicts its lookup result.
// Results are popped under changing stall patterns and compared field by
// field. The field widths and the write policy are reprogrammed between
// phases, including the widest, narrowest and out-of-range settings.
// ----------------------------------------------------------------------------
module tb_top;
  import dmc_pkg::*;

  localparam int NUM_LINES = 256;

  typedef enum int {
    POP_ALWAYS,
    POP_RANDOM,
    POP_SPARSE,
    POP_BURSTY
  } pop_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TAG_BITS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [31:0]           in_address = '0;
  logic                  out_pop = 1'b0;
  logic                  out_empty;
  logic                  out_hit;
  logic                  out_cold_miss;
  logic [LINE_IDX_W-1:0] out_line_index;
  logic [TAG_W-1:0]      out_line_tag;
  logic                  out_line_dirty;
  logic [CNT_W-1:0]      out_hit_total;
  logic [CNT_W-1:0]      out_miss_total;

  logic [31:0] address_queue[$];
  res_t        expected_lookups[$];
  int          fail_count = 0;

  logic [5:0]  tag_bits_m = 6'd8;
  logic [3:0]  index_bits_m = 4'd2;
  logic [4:0]  offset_bits_m = 5'd2;
  logic        is_load_m = 1'b1;
  logic        write_back_m = 1'b0;
  bit          line_valid_m[NUM_LINES];
  logic [31:0] line_tag_m[NUM_LINES];
  bit          line_dirty_m[NUM_LINES];
  logic [31:0] hits_m = '0;
  logic [31:0] misses_m = '0;

  int        burst_left = 1;
  int        gap_left = 0;
  int        stall_tick = 0;
  pop_mode_t pop_mode = POP_ALWAYS;

  direct_mapped_cache_tag_check dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_address    (in_address),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_hit       (out_hit),
    .out_cold_miss (out_cold_miss),
    .out_line_index(out_line_index),
    .out_line_tag  (out_line_tag),
    .out_line_dirty(out_line_dirty),
    .out_hit_total (out_hit_total),
    .out_miss_total(out_miss_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] ones_below(input int n);
    if (n >= 64) begin
      return '1;
    end
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic res_t look_up(input logic [31:0] addr_in);
    int          tw;
    int          iw;
    int          ow;
    logic [63:0] a;
    logic [7:0]  li;
    logic [31:0] tg;
    res_t        r;
    tw = (tag_bits_m > 32) ? 32 : int'(tag_bits_m);
    iw = (index_bits_m > 8) ? 8 : int'(index_bits_m);
    ow = int'(offset_bits_m);
    a = {32'd0, addr_in} & ones_below(tw + iw + ow);
    li = 8'((a >> ow) & ones_below(iw));
    tg = 32'((a >> (ow + iw)) & ones_below(tw));
    r = '0;
    if (!line_valid_m[li]) begin
      r.cold_miss = 1'b1;
    end else if (line_tag_m[li] == tg) begin
      r.hit = 1'b1;
    end
    if (r.hit) begin
      if (hits_m != '1) hits_m++;
      if (!is_load_m && write_back_m) line_dirty_m[li] = 1'b1;
    end else begin
      if (misses_m != '1) misses_m++;
      line_valid_m[li] = 1'b1;
      line_tag_m[li] = tg;
      line_dirty_m[li] = 1'b0;
    end
    r.line_index = li;
    r.line_tag = line_tag_m[li];
    r.line_dirty = line_dirty_m[li];
    r.hit_total = hits_m;
    r.miss_total = misses_m;
    return r;
  endfunction

  function automatic string show(input res_t r);
    return $sformatf("hit=%0d cold=%0d line=%0d tag=%h dirty=%0d hits=%0d misses=%0d",
                     r.hit, r.cold_miss, r.line_index, r.line_tag, r.line_dirty,
                     r.hit_total, r.miss_total);
  endfunction

  always @(posedge clk) begin : drive_items
    logic go;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        expected_lookups.insert(expected_lookups.size(), look_up(in_address));
        void'(address_queue.pop_front());
      end
      if (!(in_push && in_full)) begin
        go = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (address_queue.size() > 0) begin
          go = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            if ($urandom_range(0, 3) == 0) begin
              gap_left = 0;
              burst_left = $urandom_range(10, 40);
            end else begin
              gap_left = $urandom_range(1, 6);
              burst_left = $urandom_range(1, 8);
            end
          end
        end
        in_push <= go;
        if (go) in_address <= address_queue[0];
      end
    end
  end

  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    logic ready;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        got = {out_hit, out_cold_miss, out_line_index, out_line_tag, out_line_dirty,
               out_hit_total, out_miss_total};
        if (expected_lookups.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result: %s", show(got));
        end else begin
          want = expected_lookups.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch expected: %s", show(want));
              $display("mismatch actual:   %s", show(got));
            end
          end
        end
      end
      stall_tick++;
      if (stall_tick % 80 == 0) pop_mode = pop_mode_t'($urandom_range(0, 3));
      case (pop_mode)
        POP_ALWAYS: begin
          ready = 1'b1;
        end
        POP_RANDOM: begin
          ready = 1'($urandom_range(0, 1));
        end
        POP_SPARSE: begin
          ready = (stall_tick % 4 == 0);
        end
        default: begin
          ready = (stall_tick % 32) >= 20;
        end
      endcase
      out_pop <= ready;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TAG_BITS: begin
        tag_bits_m = val;
      end
      CFG_INDEX_BITS: begin
        index_bits_m = val[3:0];
      end
      CFG_OFFSET_BITS: begin
        offset_bits_m = val[4:0];
      end
      CFG_IS_LOAD: begin
        is_load_m = val[0];
      end
      CFG_WRITE_BACK: begin
        write_back_m = val[0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic set_config(input int tb, input int ib, input int ob, input int ld, input int wb);
    write_reg(CFG_TAG_BITS, CFG_DATA_W'(tb));
    write_reg(CFG_INDEX_BITS, CFG_DATA_W'(ib));
    write_reg(CFG_OFFSET_BITS, CFG_DATA_W'(ob));
    write_reg(CFG_IS_LOAD, CFG_DATA_W'(ld));
    write_reg(CFG_WRITE_BACK, CFG_DATA_W'(wb));
  endtask

  task automatic drain();
    while (address_queue.size() != 0 || in_push || expected_lookups.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_phase(input int count);
    int          tw;
    int          iw;
    int          ow;
    int          pick;
    logic [31:0] tags[4];
    logic [7:0]  idxs[4];
    logic [63:0] a;
    tw = (tag_bits_m > 32) ? 32 : int'(tag_bits_m);
    iw = (index_bits_m > 8) ? 8 : int'(index_bits_m);
    ow = int'(offset_bits_m);
    for (int k = 0; k < 4; k++) begin
      tags[k] = $urandom;
      idxs[k] = 8'($urandom);
    end
    tags[0] = '0;
    tags[1] = '1;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        a = {32'd0, $urandom};
      end else begin
        a = (64'(tags[$urandom_range(0, 3)]) & ones_below(tw)) << (ow + iw);
        a |= (64'(idxs[$urandom_range(0, 3)]) & ones_below(iw)) << ow;
        a |= 64'($urandom) & ones_below(ow);
        if (pick == 1) a |= {$urandom, $urandom} & ~ones_below(tw + iw + ow);
      end
      address_queue.insert(address_queue.size(), a[31:0]);
    end
  endtask

  initial begin
    for (int k = 0; k < NUM_LINES; k++) begin
      line_tag_m[k] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (in_full !== 1'b0) @(posedge clk);

    // Reset settings: cold miss, hit, hit in another word, conflict, top bits masked.
    address_queue = '{32'h0, 32'h0, 32'h3, 32'h400, 32'hFFFFFFFF, 32'hFFC};
    drain();
    // Write-back writes: a hit marks the line dirty, a conflict replaces it clean.
    set_config(8, 2, 2, 0, 1);
    address_queue = '{32'hFFF, 32'hFFD, 32'h7FC, 32'h7FC};
    drain();
    // Widest fields, total width beyond the address.
    set_config(32, 8, 31, 1, 0);
    address_queue = '{32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF};
    drain();
    // Tag and index widths above their limits, write-through writes.
    set_config(63, 15, 0, 0, 0);
    address_queue = '{32'hFFFFFFFF, 32'h12345678, 32'h12345678};
    drain();
    // All fields of zero width.
    set_config(0, 0, 0, 0, 1);
    address_queue = '{32'hDEADBEEF, 32'h0};
    drain();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: set_config(32, 8, 31, 0, 1);
        1: set_config(0, 0, 0, 0, 1);
        2: set_config(63, 15, 0, 0, 1);
        3: set_config(8, 2, 2, 1, 0);
        default: set_config($urandom_range(0, 63), $urandom_range(0, 15),
                            $urandom_range(0, 31), $urandom_range(0, 1),
                            $urandom_range(0, 1));
      endcase
      queue_phase(50);
      drain();
    end

    repeat (10) @(posedge clk);
    if (expected_lookups.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("direct_mapped_cache_tag_check regression: pass");
    end else begin
      $display("direct_mapped_cache_tag_check regression: fail");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("direct_mapped_cache_tag_check regression: fail");
    $finish;
  end

endmodule
